// ----- src/fdpq_pkg.sv -----
`default_nettype none

package fdpq_pkg;

  localparam int DELAY_W  = 24;
  localparam int HANDLE_W = 16;
  localparam int LENGTH_W = 16;
  localparam int ADDR_W   = 32;
  localparam int PORT_W   = 16;
  localparam int KIND_W   = 2;

  localparam int MAX_RESULTS = 16;
  localparam int NREL_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [DELAY_W-1:0] DELAY_RESET = 24'd1000000;

  localparam logic ACTION_ENQUEUE = 1'b0;
  localparam logic ACTION_TICK    = 1'b1;

  localparam logic [KIND_W-1:0] KIND_ACCEPT  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_DROP    = 2'd1;
  localparam logic [KIND_W-1:0] KIND_RELEASE = 2'd2;

  typedef struct packed {
    logic [DELAY_W-1:0]  remaining;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
  } entry_t;

endpackage

`default_nettype wire

// ----- src/fdpq_ifs.sv -----
`default_nettype none

interface fdpq_req_if;
  import fdpq_pkg::*;

  logic                valid;
  logic                ready;
  logic                action;
  logic [DELAY_W-1:0]  elapsed_us;
  logic [HANDLE_W-1:0] packet_handle;
  logic [LENGTH_W-1:0] packet_length;
  logic [ADDR_W-1:0]   source_addr;
  logic [PORT_W-1:0]   source_port;

  modport source (
    output valid, action, elapsed_us, packet_handle, packet_length, source_addr,
           source_port,
    input  ready
  );

  modport sink (
    input  valid, action, elapsed_us, packet_handle, packet_length, source_addr,
           source_port,
    output ready
  );
endinterface

interface fdpq_rsp_if;
  import fdpq_pkg::*;

  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [HANDLE_W-1:0] packet_handle_res;
  logic [LENGTH_W-1:0] packet_length_res;
  logic [ADDR_W-1:0]   source_addr_res;
  logic [PORT_W-1:0]   source_port_res;
  logic                last;

  modport source (
    output valid, kind, packet_handle_res, packet_length_res, source_addr_res,
           source_port_res, last,
    input  ready
  );

  modport sink (
    input  valid, kind, packet_handle_res, packet_length_res, source_addr_res,
           source_port_res, last,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/fdpq_entry_ram.sv -----
`default_nettype none

module fdpq_entry_ram #(
  parameter int DEPTH = 16,
  parameter int IDX_W = 4
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [IDX_W-1:0] waddr,
  input  wire fdpq_pkg::entry_t wdata,
  input  wire logic             re,
  input  wire logic [IDX_W-1:0] raddr,
  output fdpq_pkg::entry_t      rdata
);
  import fdpq_pkg::*;

  entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/fixed_delay_packet_queue.sv -----
`default_nettype none

// Channel  Dir  Handshake    Payload
// req      in   valid/ready  action, elapsed_us, packet_handle, packet_length,
//                            source_addr, source_port
// rsp      out  valid/ready  kind, packet_handle_res, packet_length_res,
//                            source_addr_res, source_port_res, last
// cfg      in   cfg_we       cfg_wdata (delay_us)
//
// An enqueue request gives one result and, like a tick on an empty queue, is finished in the idle state.
// Any other tick reads the first entry, then walks each entry in turn through the shared
// subtract/compare unit and the entry RAM's single read and write ports, pausing while a
// release waits on the sink, and then finishes in the flush state.
// A new result, and with it the next request, waits while the sink holds the result register.
// Reset clears the entry count and the sequencer and reloads the default delay, not the RAM.

module fixed_delay_packet_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  wire logic       clk,
  input  wire logic       rst,
  fdpq_req_if.sink        req,
  fdpq_rsp_if.source      rsp,
  input  wire logic       cfg_we,
  input  wire logic [23:0] cfg_wdata
);
  import fdpq_pkg::*;

  localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;

  logic [1:0]         state;
  logic [DELAY_W-1:0] delay_us;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   idx;
  logic [CNT_W-1:0]   wr_idx;
  logic [NREL_W-1:0]  nrel;
  logic [DELAY_W-1:0] elapsed;
  logic               pend_valid;
  entry_t             pend;

  logic               out_free;
  logic               accept;
  logic               full;
  logic [DELAY_W:0]   diff;
  logic [DELAY_W-1:0] rem;
  logic               is_rel;
  logic               stall;
  logic               advance;
  logic [CNT_W-1:0]   idx_inc;
  logic               scan_end;
  logic               rsp_load;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_waddr;
  entry_t             ram_wdata;
  logic               ram_re;
  logic [IDX_W-1:0]   ram_raddr;
  entry_t             ram_rdata;

  fdpq_entry_ram #(
    .DEPTH (QUEUE_DEPTH),
    .IDX_W (IDX_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_free  = !rsp.valid || rsp.ready;
  assign req.ready = (state == ST_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = (count == CNT_W'(QUEUE_DEPTH));

  assign diff     = {1'b0, ram_rdata.remaining} - {1'b0, elapsed};
  assign rem      = diff[DELAY_W] ? '0 : diff[DELAY_W-1:0];
  assign is_rel   = (rem == '0) && (nrel < NREL_W'(MAX_RESULTS));
  assign stall    = is_rel && pend_valid && !out_free;
  assign advance  = (state == ST_SCAN) && !stall;
  assign idx_inc  = idx + CNT_W'(1);
  assign scan_end = (idx_inc == count);

  assign rsp_load = ((state == ST_IDLE) && accept && (req.action == ACTION_ENQUEUE)) ||
                    (advance && is_rel && pend_valid) ||
                    ((state == ST_FLUSH) && pend_valid && out_free);

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count[IDX_W-1:0];
    ram_wdata = '{remaining: delay_us, handle: req.packet_handle,
                  length: req.packet_length, addr: req.source_addr,
                  port: req.source_port};
    ram_re    = 1'b0;
    ram_raddr = '0;
    if (state == ST_SCAN) begin
      ram_we    = advance && !is_rel;
      ram_waddr = wr_idx[IDX_W-1:0];
      ram_wdata = ram_rdata;
      ram_wdata.remaining = rem;
      ram_re    = advance && !scan_end;
      ram_raddr = idx_inc[IDX_W-1:0];
    end else begin
      ram_we = accept && (req.action == ACTION_ENQUEUE) && !full;
      ram_re = accept && (req.action == ACTION_TICK);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      delay_us <= DELAY_RESET;
    end else if (cfg_we) begin
      delay_us <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (rsp_load) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      idx        <= '0;
      wr_idx     <= '0;
      nrel       <= '0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            if (req.action == ACTION_ENQUEUE) begin
              rsp.kind              <= full ? KIND_DROP : KIND_ACCEPT;
              rsp.packet_handle_res <= req.packet_handle;
              rsp.packet_length_res <= req.packet_length;
              rsp.source_addr_res   <= req.source_addr;
              rsp.source_port_res   <= req.source_port;
              rsp.last              <= 1'b1;
              if (!full) begin
                count <= count + CNT_W'(1);
              end
            end else if (count != '0) begin
              elapsed    <= req.elapsed_us;
              idx        <= '0;
              wr_idx     <= '0;
              nrel       <= '0;
              pend_valid <= 1'b0;
              state      <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (advance) begin
            if (is_rel) begin
              if (pend_valid) begin
                rsp.kind              <= KIND_RELEASE;
                rsp.packet_handle_res <= pend.handle;
                rsp.packet_length_res <= pend.length;
                rsp.source_addr_res   <= pend.addr;
                rsp.source_port_res   <= pend.port;
                rsp.last              <= 1'b0;
              end
              pend       <= ram_rdata;
              pend_valid <= 1'b1;
              nrel       <= nrel + NREL_W'(1);
            end else begin
              wr_idx <= wr_idx + CNT_W'(1);
            end
            idx <= idx_inc;
            if (scan_end) begin
              state <= ST_FLUSH;
            end
          end
        end
        ST_FLUSH: begin
          if (!pend_valid) begin
            count <= wr_idx;
            state <= ST_IDLE;
          end else if (out_free) begin
            rsp.kind              <= KIND_RELEASE;
            rsp.packet_handle_res <= pend.handle;
            rsp.packet_length_res <= pend.length;
            rsp.source_addr_res   <= pend.addr;
            rsp.source_port_res   <= pend.port;
            rsp.last              <= 1'b1;
            pend_valid            <= 1'b0;
            count                 <= wr_idx;
            state                 <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none

module testbench;
  import fdpq_pkg::*;

  localparam int QUEUE_DEPTH  = 16;
  localparam int HOLD_CYCLES  = 200;
  localparam int STALL_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = QUEUE_DEPTH + 8;

  typedef struct packed {
    logic                action;
    logic [DELAY_W-1:0]  elapsed_us;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
  } request_t;

  typedef struct packed {
    logic [KIND_W-1:0]   kind;
    logic [HANDLE_W-1:0] handle;
    logic [LENGTH_W-1:0] length;
    logic [ADDR_W-1:0]   addr;
    logic [PORT_W-1:0]   port;
    logic                last;
  } outcome_t;

  class delay_line_scoreboard;
    logic [DELAY_W-1:0] delay_us;
    entry_t             queued_packets[$];
    outcome_t           expected_outcomes[$];
    int                 errors;

    function new();
      delay_us = DELAY_RESET;
      errors   = 0;
    endfunction

    function void note_request(request_t r);
      outcome_t           o;
      outcome_t           freed[$];
      entry_t             kept[$];
      entry_t             e;
      logic [DELAY_W-1:0] left;
      if (r.action == ACTION_ENQUEUE) begin
        o.kind   = (queued_packets.size() >= QUEUE_DEPTH) ? KIND_DROP : KIND_ACCEPT;
        o.handle = r.handle;
        o.length = r.length;
        o.addr   = r.addr;
        o.port   = r.port;
        o.last   = 1'b1;
        if (o.kind == KIND_ACCEPT) begin
          e.remaining = delay_us;
          e.handle    = r.handle;
          e.length    = r.length;
          e.addr      = r.addr;
          e.port      = r.port;
          queued_packets.push_back(e);
        end
        expected_outcomes.push_back(o);
      end else begin
        foreach (queued_packets[i]) begin
          e    = queued_packets[i];
          left = (e.remaining > r.elapsed_us) ? e.remaining - r.elapsed_us : '0;
          if (left == '0 && freed.size() < MAX_RESULTS) begin
            o.kind   = KIND_RELEASE;
            o.handle = e.handle;
            o.length = e.length;
            o.addr   = e.addr;
            o.port   = e.port;
            o.last   = 1'b0;
            freed.push_back(o);
          end else begin
            e.remaining = left;
            kept.push_back(e);
          end
        end
        queued_packets = kept;
        if (freed.size() > 0) freed[freed.size() - 1].last = 1'b1;
        foreach (freed[i]) expected_outcomes.push_back(freed[i]);
      end
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      errors++;
    endfunction

    function void check_result(outcome_t got);
      outcome_t want;
      if (expected_outcomes.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d handle %h",
                 $time, got.kind, got.handle);
        errors++;
        return;
      end
      want = expected_outcomes.pop_front();
      if (got.kind !== want.kind) flag("kind", 32'(want.kind), 32'(got.kind));
      if (got.handle !== want.handle)
        flag("packet_handle_res", 32'(want.handle), 32'(got.handle));
      if (got.length !== want.length)
        flag("packet_length_res", 32'(want.length), 32'(got.length));
      if (got.addr !== want.addr) flag("source_addr_res", want.addr, got.addr);
      if (got.port !== want.port) flag("source_port_res", 32'(want.port), 32'(got.port));
      if (got.last !== want.last) flag("last", 32'(want.last), 32'(got.last));
    endfunction
  endclass

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               cfg_we;
  logic [DELAY_W-1:0] cfg_wdata;
  bit                 sender_steady = 1'b0;
  bit                 receiver_steady = 1'b0;
  int                 hold_off_requests = 0;
  int                 stall_cycles = 0;
  delay_line_scoreboard board;

  fdpq_req_if req_ch();
  fdpq_rsp_if rsp_ch();

  fixed_delay_packet_queue #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) DUT (
    .clk(clk),
    .rst(rst),
    .req(req_ch.sink),
    .rsp(rsp_ch.source),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #6 clk = ~clk;

  function automatic request_t enqueue_req(logic [HANDLE_W-1:0] h, logic [LENGTH_W-1:0] l,
                                           logic [ADDR_W-1:0] a, logic [PORT_W-1:0] p);
    request_t r;
    r.action     = ACTION_ENQUEUE;
    r.elapsed_us = DELAY_W'($urandom());
    r.handle     = h;
    r.length     = l;
    r.addr       = a;
    r.port       = p;
    return r;
  endfunction

  function automatic request_t random_enqueue();
    return enqueue_req(HANDLE_W'($urandom()), LENGTH_W'($urandom()), $urandom(),
                       PORT_W'($urandom()));
  endfunction

  function automatic request_t tick_req(logic [DELAY_W-1:0] elapsed);
    request_t r;
    r            = random_enqueue();
    r.action     = ACTION_TICK;
    r.elapsed_us = elapsed;
    return r;
  endfunction

  function automatic request_t random_request(logic [DELAY_W-1:0] d);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 55) return random_enqueue();
    if (pick < 60) return tick_req('0);
    if (pick < 65) return tick_req('1);
    return tick_req(DELAY_W'($urandom_range(0, d / 3 + 2)));
  endfunction

  task automatic offer(input request_t r);
    int gap;
    if (!sender_steady && $urandom_range(0, 99) < 25) begin
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(4, 24) : $urandom_range(1, 3);
      req_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_ch.valid         <= 1'b1;
    req_ch.action        <= r.action;
    req_ch.elapsed_us    <= r.elapsed_us;
    req_ch.packet_handle <= r.handle;
    req_ch.packet_length <= r.length;
    req_ch.source_addr   <= r.addr;
    req_ch.source_port   <= r.port;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    board.note_request(r);
  endtask

  // A tick that releases nothing gives no result, so the block may still be
  // walking the queue when the last expected result has arrived.
  task automatic settle();
    req_ch.valid <= 1'b0;
    while (board.expected_outcomes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_delay(input logic [DELAY_W-1:0] value);
    settle();
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    board.delay_us = value;
  endtask

  initial begin
    board                = new();
    req_ch.valid         = 1'b0;
    req_ch.action        = ACTION_ENQUEUE;
    req_ch.elapsed_us    = '0;
    req_ch.packet_handle = '0;
    req_ch.packet_length = '0;
    req_ch.source_addr   = '0;
    req_ch.source_port   = '0;
    cfg_we               = 1'b0;
    cfg_wdata            = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    offer(tick_req('0));
    offer(enqueue_req('0, '0, '0, '0));
    offer(enqueue_req('1, '1, '1, '1));
    offer(tick_req('0));
    offer(tick_req(DELAY_W'(DELAY_RESET - 1)));
    offer(tick_req(24'd1));

    write_delay('0);
    offer(random_enqueue());
    offer(tick_req('0));

    write_delay('1);
    repeat (QUEUE_DEPTH + 1) offer(random_enqueue());
    offer(tick_req('1));

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: write_delay(24'd1);
        1: write_delay(DELAY_W'($urandom_range(10, 200)));
        2: write_delay('0);
        3: write_delay('1);
        4: write_delay(DELAY_W'($urandom_range(1, 1000)));
        default: write_delay(DELAY_RESET);
      endcase
      sender_steady   = (phase == 4);
      receiver_steady = (phase == 4);
      if (phase == 1) begin
        sender_steady = 1'b1;
        hold_off_requests++;
        repeat (30) offer(random_enqueue());
        sender_steady = 1'b0;
      end
      repeat (45) offer(random_request(board.delay_us));
    end

    settle();
    if (board.errors == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

  initial begin : receiver
    int served;
    served       = 0;
    rsp_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_requests != served) begin
        served = hold_off_requests;
        rsp_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      rsp_ch.ready <= receiver_steady || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin : take_result
    outcome_t seen;
    if (!rst && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
      seen.kind   = rsp_ch.kind;
      seen.handle = rsp_ch.packet_handle_res;
      seen.length = rsp_ch.packet_length_res;
      seen.addr   = rsp_ch.source_addr_res;
      seen.port   = rsp_ch.source_port_res;
      seen.last   = rsp_ch.last;
      board.check_result(seen);
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

endmodule

`default_nettype wire

// ----- fixed_delay_packet_queue.f -----
src/fdpq_pkg.sv
src/fdpq_ifs.sv
src/fdpq_entry_ram.sv
src/fixed_delay_packet_queue.sv
tb/testbench.sv
